// ===== rtl/hff_pkg.sv =====
package hff_pkg;

    localparam int MARKER_W  = 64;
    localparam int WIN_BYTES = MARKER_W / 8;
    localparam int OUT_OFS_W = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_MARKER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOOT_MARKER = 1'b1;

    typedef enum logic [1:0] {
        EVT_NORMAL      = 2'd0,
        EVT_CUT         = 2'd1,
        EVT_OPEN_AT_END = 2'd2
    } evt_status_t;

    typedef struct packed {
        logic [OUT_OFS_W-1:0] start_ofs;
        logic [OUT_OFS_W-1:0] end_ofs;
        evt_status_t          status;
    } event_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef struct packed {
        logic in_event;
        logic at_origin;
    } front_stat_t;

endpackage

// ===== rtl/hff_if.sv =====
interface hff_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_last;

    modport source (output valid, output data_byte, output stream_last, input ready);
    modport sink   (input valid, input data_byte, input stream_last, output ready);
endinterface

interface hff_event_if;
    logic        valid;
    logic        ready;
    logic [31:0] event_start;
    logic [31:0] event_stop;
    logic [1:0]  event_status;

    modport source (output valid, output event_start, output event_stop, output event_status,
                    input ready);
    modport sink   (input valid, input event_start, input event_stop, input event_status,
                    output ready);
endinterface

// ===== rtl/head_foot_event_framer_unit.sv =====
// Channel   Dir   Payload                                       Word accepted when
// stream    in    data_byte[7:0], stream_last                   valid && ready
// events    out   event_start[31:0], event_stop[31:0],          valid && ready
//                 event_status[1:0]
// cfg       in    cfg_index (0 head, 1 foot), cfg_data[63:0]    cfg_we
//
// One stream byte is taken per cycle while the event queue is not full; an
// event word passes from its closing byte through the queue write, then the
// output register.
// Reset clears stream state, the queue and the output register; markers read 0.
// A stall on events fills the queue; stream.ready drops only when it is full.
module head_foot_event_framer_unit #(
    parameter int HEAD_LEN    = 4,
    parameter int FOOT_LEN    = 4,
    parameter int OFFSET_BITS = 32,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    hff_byte_if.sink                      stream,
    hff_event_if.source                   events,
    input  logic                          cfg_we,
    input  logic [hff_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hff_pkg::MARKER_W-1:0]  cfg_data
);
    import hff_pkg::*;

    logic [MARKER_W-1:0] head_marker_reg;
    logic [MARKER_W-1:0] foot_marker_reg;

    logic        q_push;
    logic        q_pop;
    event_t      q_push_word;
    event_t      q_head_word;
    queue_stat_t q_stat;
    front_stat_t front_stat;

    // Marker registers: the user must write them only while the framer is idle; the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_marker_reg <= '0;
            foot_marker_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HEAD_MARKER: head_marker_reg <= cfg_data;
                CFG_FOOT_MARKER: foot_marker_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Front end: shift in bytes, match markers, decide event words
    hff_front #(
        .HEAD_LEN    (HEAD_LEN),
        .FOOT_LEN    (FOOT_LEN),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .stream      (stream),
        .head_marker (head_marker_reg),
        .foot_marker (foot_marker_reg),
        .q_stat      (q_stat),
        .push        (q_push),
        .push_word   (q_push_word),
        .stat        (front_stat)
    );

    // Short queue decouples the matcher from downstream stalls
    hff_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (q_push_word),
        .pop       (q_pop),
        .head_word (q_head_word),
        .stat      (q_stat)
    );

    // Back end: output register toward the event consumer
    hff_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .q_word (q_head_word),
        .pop    (q_pop),
        .events (events)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("event queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("event queue read while empty");

    a_clear_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (stream.valid && stream.ready && stream.stream_last)
        |=> (front_stat.at_origin && !front_stat.in_event))
        else $error("stream state not cleared after final byte");

    a_open_needs_event: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && q_push_word.status == EVT_CUT) |-> front_stat.in_event)
        else $error("cut event reported with no event open");

endmodule

// ===== rtl/hff_front.sv =====
module hff_front #(
    parameter int HEAD_LEN    = 4,
    parameter int FOOT_LEN    = 4,
    parameter int OFFSET_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    hff_byte_if.sink                      stream,
    input  logic [hff_pkg::MARKER_W-1:0]  head_marker,
    input  logic [hff_pkg::MARKER_W-1:0]  foot_marker,
    input  hff_pkg::queue_stat_t          q_stat,
    output logic                          push,
    output hff_pkg::event_t               push_word,
    output hff_pkg::front_stat_t          stat
);
    import hff_pkg::*;

    localparam int  WIN_W     = WIN_BYTES * 8;
    localparam int  HEAD_W    = HEAD_LEN * 8;
    localparam int  FOOT_W    = FOOT_LEN * 8;
    localparam bit  FOOT_WINS = (FOOT_LEN >= HEAD_LEN);

    logic [WIN_W-1:0]       window_reg, window_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [OFFSET_BITS-1:0] floor_reg, floor_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic                   in_event_reg, in_event_next;

    logic                   accept;
    logic [WIN_W-1:0]       window_shift;
    logic [OFFSET_BITS-1:0] floor_gap;
    logic [OFFSET_BITS-1:0] ofs_inc;
    logic [OFFSET_BITS-1:0] head_start;
    logic                   head_hit;
    logic                   foot_hit;

    assign stream.ready = !q_stat.full;
    assign accept       = stream.valid && stream.ready;

    assign window_shift = {window_reg[WIN_W-9:0], stream.data_byte};
    assign floor_gap    = offset_reg - floor_reg;
    assign ofs_inc      = offset_reg + OFFSET_BITS'(1);
    assign head_start   = offset_reg - OFFSET_BITS'(HEAD_LEN - 1);

    // A marker counts only when all of its bytes lie at or past the floor
    assign head_hit = (floor_gap >= OFFSET_BITS'(HEAD_LEN - 1))
                   && (window_shift[HEAD_W-1:0] == head_marker[HEAD_W-1:0]);
    assign foot_hit = in_event_reg && (floor_gap >= OFFSET_BITS'(FOOT_LEN - 1))
                   && (window_shift[FOOT_W-1:0] == foot_marker[FOOT_W-1:0]);

    always_comb
    begin
        window_next         = window_shift;
        offset_next         = ofs_inc;
        floor_next          = floor_reg;
        start_next          = start_reg;
        in_event_next       = in_event_reg;
        push                = 1'b0;
        push_word.start_ofs = OUT_OFS_W'(start_reg);
        push_word.end_ofs   = OUT_OFS_W'(ofs_inc);
        push_word.status    = EVT_NORMAL;

        if (in_event_reg)
        begin
            if (foot_hit && (!head_hit || FOOT_WINS))
            begin
                push          = accept;
                in_event_next = 1'b0;
                floor_next    = ofs_inc;
            end
            else if (head_hit)
            begin
                push              = accept;
                push_word.end_ofs = OUT_OFS_W'(head_start);
                push_word.status  = EVT_CUT;
                start_next        = head_start;
                floor_next        = ofs_inc;
            end
        end
        else if (head_hit)
        begin
            in_event_next = 1'b1;
            start_next    = head_start;
            floor_next    = ofs_inc;
        end

        if (stream.stream_last)
        begin
            // report an event left open, then drop all stream state
            if (in_event_next && !push)
            begin
                push                = accept;
                push_word.start_ofs = OUT_OFS_W'(start_next);
                push_word.end_ofs   = '0;
                push_word.status    = EVT_OPEN_AT_END;
            end
            window_next   = '0;
            offset_next   = '0;
            floor_next    = '0;
            start_next    = '0;
            in_event_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= '0;
            offset_reg   <= '0;
            floor_reg    <= '0;
            start_reg    <= '0;
            in_event_reg <= 1'b0;
        end
        else if (accept)
        begin
            window_reg   <= window_next;
            offset_reg   <= offset_next;
            floor_reg    <= floor_next;
            start_reg    <= start_next;
            in_event_reg <= in_event_next;
        end
    end

    assign stat.in_event  = in_event_reg;
    assign stat.at_origin = (offset_reg == '0) && (floor_reg == '0) && (window_reg == '0);

endmodule

// ===== rtl/hff_queue.sv =====
module hff_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  hff_pkg::event_t      push_word,
    input  logic                 pop,
    output hff_pkg::event_t      head_word,
    output hff_pkg::queue_stat_t stat
);
    import hff_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    event_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

    assign head_word  = mem[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

// ===== rtl/hff_back.sv =====
module hff_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hff_pkg::queue_stat_t q_stat,
    input  hff_pkg::event_t      q_word,
    output logic                 pop,
    hff_event_if.source          events
);
    import hff_pkg::*;

    logic   valid_reg, valid_next;
    event_t word_reg;

    // Refill the output register whenever it is empty or being drained
    assign pop        = !q_stat.empty && (!valid_reg || events.ready);
    assign valid_next = pop || (valid_reg && !events.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            word_reg <= q_word;
        end
    end

    assign events.valid        = valid_reg;
    assign events.event_start  = word_reg.start_ofs;
    assign events.event_stop   = word_reg.end_ofs;
    assign events.event_status = word_reg.status;

endmodule

// ===== sim/testbench.sv =====
module testbench;
    import hff_pkg::*;

    localparam int HEAD_LEN      = 4;
    localparam int FOOT_LEN      = 4;
    localparam int OFFSET_BITS   = 32;
    // Output passes through the queue write and the output register after the closing byte.
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 4000;
    // Long result stall that backs the block up into its input.
    localparam int HOLD_CYCLES   = 200;
    localparam int RAND_PHASES   = 6;
    localparam int PHASE_WORDS   = 135;

    // Event predictor: tracks the byte window and framing state, and keeps
    // the events still owed by the block, oldest first.
    class event_ledger;
        logic [MARKER_W-1:0]    head_pat;
        logic [MARKER_W-1:0]    foot_pat;
        logic [MARKER_W-1:0]    tail_bytes;
        logic [OFFSET_BITS-1:0] next_ofs;
        logic [OFFSET_BITS-1:0] open_ofs;
        logic [OFFSET_BITS-1:0] free_from;
        bit                     open_evt;
        event_t                 owed[$];
        int                     failures;
        int                     shown;

        function new();
            head_pat = '0;
            foot_pat = '0;
            failures = 0;
            shown    = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            tail_bytes = '0;
            next_ofs   = '0;
            open_evt   = 1'b0;
            open_ofs   = '0;
            free_from  = '0;
        endfunction

        function void set_marker(logic [CFG_IDX_W-1:0] idx, logic [MARKER_W-1:0] val);
            case (idx)
                CFG_HEAD_MARKER: head_pat = val;
                CFG_FOOT_MARKER: foot_pat = val;
                default: ;
            endcase
        endfunction

        // A marker counts only once all its bytes sit at or past the floor.
        function bit pattern_seen(logic [MARKER_W-1:0] pat, int len,
                                  logic [OFFSET_BITS-1:0] span);
            logic [MARKER_W-1:0] keep;
            keep = {MARKER_W{1'b1}} >> (MARKER_W - 8 * len);
            if (span < OFFSET_BITS'(len - 1))
                return 1'b0;
            return (tail_bytes & keep) == (pat & keep);
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            logic [OFFSET_BITS-1:0] span;
            logic [OFFSET_BITS-1:0] after;
            logic [OFFSET_BITS-1:0] head_at;
            bit                     head_hit;
            bit                     foot_hit;
            bit                     emitted;
            event_t                 ev;
            span       = next_ofs - free_from;
            after      = next_ofs + OFFSET_BITS'(1);
            head_at    = next_ofs - OFFSET_BITS'(HEAD_LEN - 1);
            tail_bytes = {tail_bytes[MARKER_W-9:0], b};
            head_hit   = pattern_seen(head_pat, HEAD_LEN, span);
            foot_hit   = open_evt && pattern_seen(foot_pat, FOOT_LEN, span);
            emitted    = 1'b0;
            ev         = '0;

            if (open_evt) begin
                // Same closing byte: the earlier-starting marker wins, foot on a tie.
                if (foot_hit && (!head_hit || FOOT_LEN >= HEAD_LEN)) begin
                    ev.start_ofs = OUT_OFS_W'(open_ofs);
                    ev.end_ofs   = OUT_OFS_W'(after);
                    ev.status    = EVT_NORMAL;
                    emitted      = 1'b1;
                    open_evt     = 1'b0;
                    free_from    = after;
                end else if (head_hit) begin
                    ev.start_ofs = OUT_OFS_W'(open_ofs);
                    ev.end_ofs   = OUT_OFS_W'(head_at);
                    ev.status    = EVT_CUT;
                    emitted      = 1'b1;
                    open_ofs     = head_at;
                    free_from    = after;
                end
            end else if (head_hit) begin
                open_evt  = 1'b1;
                open_ofs  = head_at;
                free_from = after;
            end

            if (last) begin
                // An open event is reported unless this byte emitted one, as a cut head does; the state then clears.
                if (open_evt && !emitted) begin
                    ev.start_ofs = OUT_OFS_W'(open_ofs);
                    ev.end_ofs   = '0;
                    ev.status    = EVT_OPEN_AT_END;
                    emitted      = 1'b1;
                end
                clear_stream();
            end else begin
                next_ofs = after;
            end

            if (emitted)
                owed = {owed, ev};
        endfunction

        function void report(string what, event_t want, event_t got);
            failures++;
            if (shown < 10) begin
                shown++;
                $display("%0t mismatch (%s):", $time, what,
                         " expected start=%0d end=%0d status=%0d,",
                         want.start_ofs, want.end_ofs, want.status,
                         " got start=%0d end=%0d status=%0d",
                         got.start_ofs, got.end_ofs, got.status);
            end
        endfunction

        function void check_event(event_t got);
            event_t want;
            if (owed.size() == 0) begin
                report("no event owed", '0, got);
                return;
            end
            want = owed.pop_front();
            if (got.start_ofs != want.start_ofs)
                report("event_start", want, got);
            else if (got.end_ofs != want.end_ofs)
                report("event_stop", want, got);
            else if (got.status != want.status)
                report("event_status", want, got);
        endfunction
    endclass

    logic                 clk   = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MARKER_W-1:0]  cfg_data;

    // calm: both sides run without idle cycles. hold_req: sink stalls long.
    bit calm     = 1'b0;
    bit hold_req = 1'b0;

    event_ledger ledger = new();
    event_t      seen;

    hff_byte_if  stream_ch ();
    hff_event_if event_ch ();

    head_foot_event_framer_unit #(
        .HEAD_LEN   (HEAD_LEN),
        .FOOT_LEN   (FOOT_LEN),
        .OFFSET_BITS(OFFSET_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .stream   (stream_ch),
        .events   (event_ch),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #10 clk = ~clk;

    // Watch both channels at the edge. Pre-edge values are what the block
    // sees, so a word counts exactly when valid and ready were both high.
    always @(posedge clk) begin
        if (rst_n && stream_ch.valid && stream_ch.ready)
            ledger.note_byte(stream_ch.data_byte, stream_ch.stream_last);
        if (rst_n && event_ch.valid && event_ch.ready) begin
            seen.start_ofs = event_ch.event_start;
            seen.end_ofs   = event_ch.event_stop;
            seen.status    = evt_status_t'(event_ch.event_status);
            ledger.check_event(seen);
        end
    end

    // Offer one stream word after a random gap and hold it until taken.
    task automatic send_word(logic [7:0] b, logic last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            stream_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        stream_ch.valid       <= 1'b1;
        stream_ch.data_byte   <= b;
        stream_ch.stream_last <= last;
        @(posedge clk);
        while (!stream_ch.ready)
            @(posedge clk);
    endtask

    // Send the first cnt bytes of a marker, first byte most significant;
    // flag the final one as the end of the stream if asked.
    task automatic send_marker(logic [MARKER_W-1:0] pat, int len, int cnt, logic last);
        for (int k = 0; k < cnt; k++)
            send_word(pat[8 * (len - 1 - k) +: 8], last && (k == cnt - 1));
    endtask

    // Write both markers; only legal while the block is idle.
    task automatic program_markers(logic [MARKER_W-1:0] head, logic [MARKER_W-1:0] foot);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_HEAD_MARKER;
        cfg_data  <= head;
        @(posedge clk);
        ledger.set_marker(CFG_HEAD_MARKER, head);
        cfg_index <= CFG_FOOT_MARKER;
        cfg_data  <= foot;
        @(posedge clk);
        ledger.set_marker(CFG_FOOT_MARKER, foot);
        cfg_we    <= 1'b0;
    endtask

    // Drop valid, wait for every owed event, then let the pipe settle so a
    // following register write cannot race an event still in flight.
    task automatic finish_phase();
        int guard;
        stream_ch.valid <= 1'b0;
        @(posedge clk);
        guard = 0;
        while (ledger.owed.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge clk);
            guard++;
        end
        if (ledger.owed.size() != 0) begin
            ledger.report("event never came", ledger.owed[0], '0);
            ledger.owed.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Half marker bytes, so partial and overlapping matches show up often.
    function automatic logic [7:0] pick_byte(logic [MARKER_W-1:0] head,
                                             logic [MARKER_W-1:0] foot);
        case ($urandom_range(0, 3))
            0, 1:    return 8'($urandom_range(0, 255));
            2:       return head[8 * $urandom_range(0, HEAD_LEN - 1) +: 8];
            default: return foot[8 * $urandom_range(0, FOOT_LEN - 1) +: 8];
        endcase
    endfunction

    function automatic logic [MARKER_W-1:0] two_letter_marker();
        logic [MARKER_W-1:0] pat;
        pat = {$urandom, $urandom};
        for (int k = 0; k < 4; k++)
            pat[8 * k +: 8] = $urandom_range(0, 1) ? 8'hAA : 8'h55;
        return pat;
    endfunction

    // Random framing: whole heads and feet, broken markers and noise runs,
    // with the stream ending now and then on the last byte of a piece.
    task automatic random_stream(int words, logic [MARKER_W-1:0] head,
                                 logic [MARKER_W-1:0] foot, bit squeeze);
        int   sent;
        int   run;
        int   kind;
        bit   squeezed;
        logic last;
        sent     = 0;
        squeezed = 1'b0;
        while (sent < words) begin
            if ($urandom_range(0, 7) == 0)
                calm = ($urandom_range(0, 2) == 0);
            if (squeeze && !squeezed && sent >= 40) begin
                squeezed = 1'b1;
                calm     = 1'b1;
                hold_req = 1'b1;
            end
            kind = $urandom_range(0, 9);
            last = ($urandom_range(0, 11) == 0);
            case (kind)
                0, 1, 2: begin
                    send_marker(head, HEAD_LEN, HEAD_LEN, last);
                    sent += HEAD_LEN;
                end
                3, 4, 5: begin
                    send_marker(foot, FOOT_LEN, FOOT_LEN, last);
                    sent += FOOT_LEN;
                end
                6: begin
                    if ($urandom_range(0, 1)) begin
                        run = $urandom_range(1, HEAD_LEN - 1);
                        send_marker(head, HEAD_LEN, run, last);
                    end else begin
                        run = $urandom_range(1, FOOT_LEN - 1);
                        send_marker(foot, FOOT_LEN, run, last);
                    end
                    sent += run;
                end
                default: begin
                    run = $urandom_range(1, 6);
                    for (int k = 0; k < run; k++)
                        send_word(pick_byte(head, foot), last && (k == run - 1));
                    sent += run;
                end
            endcase
        end
    endtask

    // Event sink: random stall per word, plus one long hold-off on request.
    initial begin : result_sink
        int wait_cycles;
        event_ch.ready <= 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req    = 1'b0;
                wait_cycles = HOLD_CYCLES;
            end else begin
                wait_cycles = calm ? 0 : $urandom_range(0, 4);
            end
            if (wait_cycles > 0) begin
                event_ch.ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            event_ch.ready <= 1'b1;
            @(posedge clk);
            while (!event_ch.valid)
                @(posedge clk);
        end
    end

    // Hard stop for a hung run.
    initial begin : watchdog
        #5000000;
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        logic [MARKER_W-1:0] head;
        logic [MARKER_W-1:0] foot;

        stream_ch.valid       <= 1'b0;
        stream_ch.data_byte   <= '0;
        stream_ch.stream_last <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_index             <= CFG_HEAD_MARKER;
        cfg_data              <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Head right at offset 0, a second head cutting it, then a third
        // head whose last byte ends the stream: two cut events, and the
        // event opened on the final byte is dropped. The head carries the
        // byte extremes 00 and FF.
        head = 64'hDEAD_BEEF_00FF_5AA5;
        foot = '1;
        program_markers(head, foot);
        send_marker(head, HEAD_LEN, HEAD_LEN, 1'b0);
        send_marker(head, HEAD_LEN, HEAD_LEN, 1'b0);
        send_marker(head, HEAD_LEN, HEAD_LEN, 1'b1);
        finish_phase();

        // Head equal to foot: the second copy ends both markers on the same
        // byte and the foot wins; the third opens an event left open when
        // the stream ends.
        head = 64'h0123_4567_C33C_0F5A;
        program_markers(head, head);
        send_marker(head, HEAD_LEN, HEAD_LEN, 1'b0);
        send_marker(head, HEAD_LEN, HEAD_LEN, 1'b0);
        send_marker(head, HEAD_LEN, HEAD_LEN, 1'b1);
        finish_phase();

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            case (phase)
                0: begin
                    head = '0;
                    foot = '0;
                end
                1: begin
                    head = '1;
                    foot = '0;
                end
                2: begin
                    head = {$urandom, $urandom};
                    foot = '1;
                end
                5: begin
                    head = two_letter_marker();
                    foot = two_letter_marker();
                end
                default: begin
                    head = {$urandom, $urandom};
                    foot = {$urandom, $urandom};
                end
            endcase
            program_markers(head, foot);
            // Phase 3 carries the long sink stall that fills the queue.
            random_stream(PHASE_WORDS, head, foot, phase == 3);
            finish_phase();
        end

        if (ledger.failures == 0 && ledger.owed.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
